/* rtl/gcde_pkg.sv */
package gcde_pkg;

    // Coordinates are degrees scaled by 2^FRAC_BITS.
    localparam int FRAC_BITS     = 20;
    localparam int CORDIC_STAGES = 24;
    localparam int ROM_SIZE      = 32;

    localparam int LAT_W   = 28;
    localparam int LON_W   = 29;
    localparam int DEG_W   = 30;
    localparam int TRIG_W  = 32;
    localparam int ANG_W   = 34;
    localparam int RAD_W   = 61;
    localparam int ROOT_W  = (RAD_W + 1) / 2;
    localparam int DIST_W  = 25;
    localparam int NUM_W   = DIST_W + 1;
    localparam int SPEED_W = 12;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    localparam int FULL_TURN = 360 * (2 ** FRAC_BITS);
    localparam int HALF_TURN = 180 * (2 ** FRAC_BITS);

    // round(3.14159265359 * 2^30) and round(3.14159265359 / 180 * 2^36)
    localparam logic [32:0] PI_Q30         = 33'd3373259426;
    localparam logic [30:0] DEG2RAD_K36    = 31'd1199381129;
    localparam logic [22:0] EARTH_RADIUS_M = 23'd6399000;
    localparam logic [SPEED_W-1:0] SPEED_RESET = 12'd10;

    typedef enum logic [0:0] {
        REG_SPEED = 1'b0
    } t_reg_idx;

    // atan(2^-n) in Q60 by its power series, n >= 1.
    function automatic logic signed [63:0] atan_series_q60(input int n);
        logic signed [63:0] sum;
        logic signed [63:0] term;
        int e;
        sum = '0;
        for (int k = 0; k < 31; k++) begin
            e = n * (2 * k + 1);
            if (e <= 60) begin
                term = (64'sd1 <<< (60 - e)) / 64'(2 * k + 1);
                sum = k[0] ? sum - term : sum + term;
            end
        end
        return sum;
    endfunction

    // Arctangent table entry round(atan(2^-n) * 2^30); pi/4 is built as
    // atan(1/2) + atan(1/3).
    function automatic logic [31:0] atan_q30(input int n);
        logic signed [63:0] third;
        logic signed [63:0] p;
        logic signed [63:0] term;
        logic signed [63:0] acc;
        third = '0;
        p = (64'sd1 <<< 60) / 64'sd3;
        for (int k = 0; k < 32; k++) begin
            if (p != 0) begin
                term = p / 64'(2 * k + 1);
                third = k[0] ? third - term : third + term;
                p = p / 64'sd9;
            end
        end
        if (n == 0) acc = atan_series_q60(1) + third;
        else        acc = atan_series_q60(n);
        return 32'((acc + (64'sd1 <<< 29)) >>> 30);
    endfunction

    // CORDIC gain in Q30, the square root of the product of (1 + 2^-2i);
    // the rotation starts at 2^30 divided by this value.
    function automatic logic [63:0] cordic_gain_root(input int n);
        logic [63:0] g;
        logic [63:0] num;
        logic [63:0] res;
        logic [63:0] bit_v;
        g = 64'd1 << 60;
        for (int i = 0; i < ROM_SIZE; i++) begin
            if (i < n) g = g + (g >> (2 * i));
        end
        num = g;
        res = '0;
        bit_v = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (bit_v > num) bit_v = bit_v >> 2;
        end
        for (int i = 0; i < 32; i++) begin
            if (bit_v != 0) begin
                if (num >= res + bit_v) begin
                    num = num - (res + bit_v);
                    res = (res >> 1) + bit_v;
                end else begin
                    res = res >> 1;
                end
                bit_v = bit_v >> 2;
            end
        end
        return res;
    endfunction

endpackage

/* rtl/gcde_sincos.sv */
module gcde_sincos #(
    parameter int STAGES = gcde_pkg::CORDIC_STAGES,
    parameter int SIDE_W = 1
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic signed [gcde_pkg::DEG_W-1:0]   i_deg,
    input  logic [SIDE_W-1:0]                   i_side,
    output logic                                o_valid,
    output logic signed [gcde_pkg::TRIG_W-1:0]  o_cos,
    output logic signed [gcde_pkg::TRIG_W-1:0]  o_sin,
    output logic [SIDE_W-1:0]                   o_side
);

    localparam int ANG_W  = gcde_pkg::ANG_W;
    localparam int RED_W  = gcde_pkg::DEG_W + 1;
    localparam int MAG_W  = gcde_pkg::DEG_W - 2;
    localparam int PROD_W = MAG_W + 31;
    localparam int RSH    = gcde_pkg::FRAC_BITS + 6;

    localparam logic signed [RED_W-1:0] FULL_S = RED_W'(gcde_pkg::FULL_TURN);
    localparam logic signed [RED_W-1:0] HALF_S = RED_W'(gcde_pkg::HALF_TURN);
    localparam logic signed [ANG_W-1:0] PI_S   = ANG_W'(gcde_pkg::PI_Q30);
    localparam logic signed [ANG_W-1:0] HP_S   = ANG_W'(gcde_pkg::PI_Q30 >> 1);
    localparam logic [63:0] GAIN_ROOT = gcde_pkg::cordic_gain_root(STAGES);
    localparam logic signed [ANG_W-1:0] START  =
        ANG_W'(((64'd1 << 60) + (GAIN_ROOT >> 1)) / GAIN_ROOT);

    // Stage 1: reduce to one turn and fold into [-180, 180] degrees.
    logic signed [RED_W-1:0] s_d;
    logic                    s_neg;
    logic [MAG_W-1:0]        s_mag;

    always_comb begin
        s_d = RED_W'(i_deg);
        if (s_d >= FULL_S)       s_d = s_d - FULL_S;
        else if (s_d <= -FULL_S) s_d = s_d + FULL_S;
        if (s_d > HALF_S)        s_d = s_d - FULL_S;
        else if (s_d < -HALF_S)  s_d = s_d + FULL_S;
        s_neg = s_d[RED_W-1];
        s_mag = s_neg ? MAG_W'(-s_d) : MAG_W'(s_d);
    end

    logic              r1_valid, r2_valid, r3_valid;
    logic [MAG_W-1:0]  r1_mag;
    logic              r1_neg, r2_neg;
    logic [SIDE_W-1:0] r1_side, r2_side, r3_side;
    logic [PROD_W-1:0] r2_prod;
    logic signed [ANG_W-1:0] r3_z;
    logic              r3_flip;

    // Stage 3: round to Q30 radians and fold into [-pi/2, pi/2].
    logic [PROD_W:0]         s_round;
    logic signed [ANG_W-1:0] s_a;
    logic signed [ANG_W-1:0] s_z;
    logic                    s_flip;

    always_comb begin
        s_round = {1'b0, r2_prod} + ((PROD_W + 1)'(1) << (RSH - 1));
        s_a = ANG_W'(s_round >> RSH);
        if (r2_neg) s_a = -s_a;
        if (s_a > HP_S) begin
            s_z = PI_S - s_a;
            s_flip = 1'b1;
        end else if (s_a < -HP_S) begin
            s_z = -PI_S - s_a;
            s_flip = 1'b1;
        end else begin
            s_z = s_a;
            s_flip = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_mag  <= s_mag;
        r1_neg  <= s_neg;
        r1_side <= i_side;
        r2_prod <= PROD_W'(r1_mag) * PROD_W'(gcde_pkg::DEG2RAD_K36);
        r2_neg  <= r1_neg;
        r2_side <= r1_side;
        r3_z    <= s_z;
        r3_flip <= s_flip;
        r3_side <= s_z == s_z ? r2_side : r2_side;
    end

    // Rotation-mode CORDIC, one micro-rotation per stage.
    logic signed [ANG_W-1:0] r_x [STAGES];
    logic signed [ANG_W-1:0] r_y [STAGES];
    logic signed [ANG_W-1:0] r_z [STAGES];
    logic                    r_f [STAGES];
    logic                    r_v [STAGES];
    logic [SIDE_W-1:0]       r_s [STAGES];

    for (genvar i = 0; i < STAGES; i++) begin : g_rot
        localparam logic signed [ANG_W-1:0] ATAN = ANG_W'(gcde_pkg::atan_q30(i));
        logic signed [ANG_W-1:0] s_xi, s_yi, s_zi;
        logic                    s_fi, s_vi;
        logic [SIDE_W-1:0]       s_si;

        if (i == 0) begin : g_first
            assign s_xi = START;
            assign s_yi = '0;
            assign s_zi = r3_z;
            assign s_fi = r3_flip;
            assign s_vi = r3_valid;
            assign s_si = r3_side;
        end else begin : g_next
            assign s_xi = r_x[i-1];
            assign s_yi = r_y[i-1];
            assign s_zi = r_z[i-1];
            assign s_fi = r_f[i-1];
            assign s_vi = r_v[i-1];
            assign s_si = r_s[i-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_v[i] <= 1'b0;
            else          r_v[i] <= s_vi;
        end

        always_ff @(posedge i_clk) begin
            if (s_zi >= 0) begin
                r_x[i] <= s_xi - (s_yi >>> i);
                r_y[i] <= s_yi + (s_xi >>> i);
                r_z[i] <= s_zi - ATAN;
            end else begin
                r_x[i] <= s_xi + (s_yi >>> i);
                r_y[i] <= s_yi - (s_xi >>> i);
                r_z[i] <= s_zi + ATAN;
            end
            r_f[i] <= s_fi;
            r_s[i] <= s_si;
        end
    end

    assign o_valid = r_v[STAGES-1];
    assign o_side  = r_s[STAGES-1];
    assign o_cos   = r_f[STAGES-1] ? gcde_pkg::TRIG_W'(-r_x[STAGES-1])
                                   : gcde_pkg::TRIG_W'(r_x[STAGES-1]);
    assign o_sin   = gcde_pkg::TRIG_W'(r_y[STAGES-1]);

endmodule

/* rtl/gcde_isqrt.sv */
module gcde_isqrt #(
    parameter int SIDE_W = 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [gcde_pkg::RAD_W-1:0]   i_rad,
    input  logic [SIDE_W-1:0]            i_side,
    output logic                         o_valid,
    output logic [gcde_pkg::ROOT_W-1:0]  o_root,
    output logic [SIDE_W-1:0]            o_side
);

    localparam int RAD_W  = gcde_pkg::RAD_W;
    localparam int ROOT_W = gcde_pkg::ROOT_W;

    // One root bit per stage, most significant first; the remainder holds
    // the radicand minus the square of the partial root.
    logic [RAD_W-1:0]  r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    logic              r_v    [ROOT_W];
    logic [SIDE_W-1:0] r_s    [ROOT_W];

    for (genvar i = 0; i < ROOT_W; i++) begin : g_bit
        localparam int K = ROOT_W - 1 - i;
        logic [RAD_W-1:0]  s_rem;
        logic [ROOT_W-1:0] s_root;
        logic              s_v;
        logic [SIDE_W-1:0] s_s;
        logic [RAD_W:0]    s_trial;

        if (i == 0) begin : g_first
            assign s_rem  = i_rad;
            assign s_root = '0;
            assign s_v    = i_valid;
            assign s_s    = i_side;
        end else begin : g_next
            assign s_rem  = r_rem[i-1];
            assign s_root = r_root[i-1];
            assign s_v    = r_v[i-1];
            assign s_s    = r_s[i-1];
        end

        assign s_trial = ((RAD_W + 1)'(s_root) << (K + 1)) + ((RAD_W + 1)'(1) << (2 * K));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_v[i] <= 1'b0;
            else          r_v[i] <= s_v;
        end

        always_ff @(posedge i_clk) begin
            if (s_trial <= {1'b0, s_rem}) begin
                r_rem[i]  <= s_rem - s_trial[RAD_W-1:0];
                r_root[i] <= s_root | (ROOT_W'(1) << K);
            end else begin
                r_rem[i]  <= s_rem;
                r_root[i] <= s_root;
            end
            r_s[i] <= s_s;
        end
    end

    assign o_valid = r_v[ROOT_W-1];
    assign o_root  = r_root[ROOT_W-1];
    assign o_side  = r_s[ROOT_W-1];

endmodule

/* rtl/gcde_vec.sv */
module gcde_vec #(
    parameter int STAGES = gcde_pkg::CORDIC_STAGES,
    parameter int SIDE_W = 1
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  logic [gcde_pkg::ROOT_W-1:0]        i_x,
    input  logic [gcde_pkg::ROOT_W-1:0]        i_y,
    input  logic [SIDE_W-1:0]                  i_side,
    output logic                               o_valid,
    output logic signed [gcde_pkg::ANG_W-1:0]  o_z,
    output logic [SIDE_W-1:0]                  o_side
);

    localparam int ANG_W = gcde_pkg::ANG_W;

    // Vectoring-mode CORDIC: drive y to zero and collect the angle in z.
    logic signed [ANG_W-1:0] r_x [STAGES];
    logic signed [ANG_W-1:0] r_y [STAGES];
    logic signed [ANG_W-1:0] r_z [STAGES];
    logic                    r_v [STAGES];
    logic [SIDE_W-1:0]       r_s [STAGES];

    for (genvar i = 0; i < STAGES; i++) begin : g_vec
        localparam logic signed [ANG_W-1:0] ATAN = ANG_W'(gcde_pkg::atan_q30(i));
        logic signed [ANG_W-1:0] s_xi, s_yi, s_zi;
        logic                    s_vi;
        logic [SIDE_W-1:0]       s_si;

        if (i == 0) begin : g_first
            assign s_xi = ANG_W'(i_x);
            assign s_yi = ANG_W'(i_y);
            assign s_zi = '0;
            assign s_vi = i_valid;
            assign s_si = i_side;
        end else begin : g_next
            assign s_xi = r_x[i-1];
            assign s_yi = r_y[i-1];
            assign s_zi = r_z[i-1];
            assign s_vi = r_v[i-1];
            assign s_si = r_s[i-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_v[i] <= 1'b0;
            else          r_v[i] <= s_vi;
        end

        always_ff @(posedge i_clk) begin
            if (s_yi >= 0) begin
                r_x[i] <= s_xi + (s_yi >>> i);
                r_y[i] <= s_yi - (s_xi >>> i);
                r_z[i] <= s_zi + ATAN;
            end else begin
                r_x[i] <= s_xi - (s_yi >>> i);
                r_y[i] <= s_yi + (s_xi >>> i);
                r_z[i] <= s_zi - ATAN;
            end
            r_s[i] <= s_si;
        end
    end

    assign o_valid = r_v[STAGES-1];
    assign o_z     = r_z[STAGES-1];
    assign o_side  = r_s[STAGES-1];

endmodule

/* rtl/gcde_div.sv */
module gcde_div #(
    parameter int SIDE_W = 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [gcde_pkg::NUM_W-1:0]    i_num,
    input  logic [gcde_pkg::SPEED_W-1:0]  i_den,
    input  logic [SIDE_W-1:0]             i_side,
    output logic                          o_valid,
    output logic [gcde_pkg::NUM_W-1:0]    o_quo,
    output logic [SIDE_W-1:0]             o_side
);

    localparam int NUM_W = gcde_pkg::NUM_W;
    localparam int DEN_W = gcde_pkg::SPEED_W;

    // Restoring division, one quotient bit per stage, by the live speed
    // register; the user must change it only while idle, unenforced.
    logic [NUM_W-1:0]  r_num [NUM_W];
    logic [DEN_W-1:0]  r_rem [NUM_W];
    logic [NUM_W-1:0]  r_quo [NUM_W];
    logic              r_v   [NUM_W];
    logic [SIDE_W-1:0] r_s   [NUM_W];

    for (genvar i = 0; i < NUM_W; i++) begin : g_bit
        localparam int K = NUM_W - 1 - i;
        logic [NUM_W-1:0]  s_num;
        logic [DEN_W-1:0]  s_rem;
        logic [NUM_W-1:0]  s_quo;
        logic              s_v;
        logic [SIDE_W-1:0] s_s;
        logic [DEN_W:0]    s_sh;
        logic              s_ge;

        if (i == 0) begin : g_first
            assign s_num = i_num;
            assign s_rem = '0;
            assign s_quo = '0;
            assign s_v   = i_valid;
            assign s_s   = i_side;
        end else begin : g_next
            assign s_num = r_num[i-1];
            assign s_rem = r_rem[i-1];
            assign s_quo = r_quo[i-1];
            assign s_v   = r_v[i-1];
            assign s_s   = r_s[i-1];
        end

        assign s_sh = {s_rem, s_num[K]};
        assign s_ge = s_sh >= {1'b0, i_den};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_v[i] <= 1'b0;
            else          r_v[i] <= s_v;
        end

        always_ff @(posedge i_clk) begin
            r_num[i] <= s_num;
            r_rem[i] <= s_ge ? DEN_W'(s_sh - {1'b0, i_den}) : DEN_W'(s_sh);
            r_quo[i] <= s_quo | (NUM_W'(s_ge) << K);
            r_s[i]   <= s_s;
        end
    end

    assign o_valid = r_v[NUM_W-1];
    assign o_quo   = r_quo[NUM_W-1];
    assign o_side  = r_s[NUM_W-1];

endmodule

/* rtl/great_circle_distance_eta_unit.sv */
// Great-circle distance and travel time between two points.
// Input: pulse start with the four coordinate ports (degrees scaled by 2^20);
// busy is always low, so a new point pair can be started in every cycle.
// Output: o_done is high for one cycle with o_distance_m (whole meters,
// floored, law of cosines on a 6399000 m sphere) and o_duration_s (distance
// over the configured speed, rounded up). Equal points give zero for both.
// A speed of zero gives an all-ones duration.
// Results come out in start order at one per cycle. The pipeline runs
// through the sine/cosine CORDIC, the one-bit-per-stage square root, the
// arccosine CORDIC and the one-bit-per-stage divider, plus the multiply
// stages around them. The receiver cannot hold results off and none is
// needed: nothing stalls.
// The APB port holds speed_mps at address 0 (reset value 10); write it only
// while no point pair is in flight. Reset empties the pipeline.
module great_circle_distance_eta_unit #(
    parameter int CORDIC_STAGES = gcde_pkg::CORDIC_STAGES
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [gcde_pkg::APB_AW-1:0]         paddr,
    input  logic [gcde_pkg::APB_DW-1:0]         pwdata,
    output logic [gcde_pkg::APB_DW-1:0]         prdata,
    output logic                                pready,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [gcde_pkg::LAT_W-1:0]   i_origin_lat,
    input  logic signed [gcde_pkg::LON_W-1:0]   i_origin_lon,
    input  logic signed [gcde_pkg::LAT_W-1:0]   i_dest_lat,
    input  logic signed [gcde_pkg::LON_W-1:0]   i_dest_lon,
    output logic                                o_done,
    output logic [gcde_pkg::DIST_W-1:0]         o_distance_m,
    output logic [gcde_pkg::DIST_W-1:0]         o_duration_s
);

    localparam int DEG_W   = gcde_pkg::DEG_W;
    localparam int TRIG_W  = gcde_pkg::TRIG_W;
    localparam int ANG_W   = gcde_pkg::ANG_W;
    localparam int RAD_W   = gcde_pkg::RAD_W;
    localparam int ROOT_W  = gcde_pkg::ROOT_W;
    localparam int DIST_W  = gcde_pkg::DIST_W;
    localparam int NUM_W   = gcde_pkg::NUM_W;
    localparam int SPEED_W = gcde_pkg::SPEED_W;
    localparam int MUL_W   = 2 * TRIG_W;
    localparam int SUM_W   = TRIG_W + 2;
    localparam int TH_W    = 32;
    localparam int DP_W    = TH_W + 23;

    localparam logic signed [SUM_W-1:0] ONE_Q30 = SUM_W'(64'd1 << 30);
    localparam logic signed [ANG_W:0]   PI_S    = (ANG_W + 1)'(gcde_pkg::PI_Q30);

    // Configuration register.
    logic [SPEED_W-1:0] r_speed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed <= gcde_pkg::SPEED_RESET;
        end else if (psel && penable && pwrite && pready) begin
            unique case (gcde_pkg::t_reg_idx'(paddr[2]))
                gcde_pkg::REG_SPEED: r_speed <= pwdata[SPEED_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (gcde_pkg::t_reg_idx'(paddr[2]))
            gcde_pkg::REG_SPEED: prdata = gcde_pkg::APB_DW'(r_speed);
            default:             prdata = '0;
        endcase
    end

    assign pready = 1'b1;
    assign busy   = 1'b0;

    // Input stage.
    logic                    r0_valid;
    logic signed [DEG_W-1:0] r0_olat, r0_dlat, r0_dlon;
    logic                    r0_same;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r0_valid <= 1'b0;
        else          r0_valid <= start && !busy;
    end

    always_ff @(posedge i_clk) begin
        r0_olat <= DEG_W'(i_origin_lat);
        r0_dlat <= DEG_W'(i_dest_lat);
        r0_dlon <= DEG_W'(i_dest_lon) - DEG_W'(i_origin_lon);
        r0_same <= (i_origin_lat == i_dest_lat) && (i_origin_lon == i_dest_lon);
    end

    // Sine and cosine of both latitudes and of the longitude difference.
    logic                     s_trig_valid, s_trig_same;
    logic signed [TRIG_W-1:0] s_c1, s_s1, s_c2, s_s2, s_cd;

    gcde_sincos #(.STAGES(CORDIC_STAGES), .SIDE_W(1)) u_trig_olat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r0_valid),
        .i_deg   (r0_olat),
        .i_side  (r0_same),
        .o_valid (s_trig_valid),
        .o_cos   (s_c1),
        .o_sin   (s_s1),
        .o_side  (s_trig_same)
    );

    gcde_sincos #(.STAGES(CORDIC_STAGES), .SIDE_W(1)) u_trig_dlat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r0_valid),
        .i_deg   (r0_dlat),
        .i_side  (1'b0),
        .o_valid (),
        .o_cos   (s_c2),
        .o_sin   (s_s2),
        .o_side  ()
    );

    gcde_sincos #(.STAGES(CORDIC_STAGES), .SIDE_W(1)) u_trig_dlon (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r0_valid),
        .i_deg   (r0_dlon),
        .i_side  (1'b0),
        .o_valid (),
        .o_cos   (s_cd),
        .o_sin   (),
        .o_side  ()
    );

    // cos(theta) = cos(lat1) cos(lat2) cos(dlon) + sin(lat1) sin(lat2),
    // then the radicand 1 - cos^2 for the sine of theta.
    logic                     r1_valid, r2_valid, r3_valid, r4_valid, r5_valid;
    logic                     r1_same, r2_same, r3_same, r4_same, r5_same;
    logic signed [MUL_W-1:0]  r1_cc, r1_ss, r2_tc;
    logic signed [TRIG_W-1:0] r1_cd, r2_ss, r3_c;
    logic [RAD_W-1:0]         r4_csq, r5_rad;
    logic [ROOT_W-1:0]        r4_cabs, r5_cabs;
    logic                     r4_neg, r5_neg;

    logic signed [TRIG_W-1:0] s_t;
    logic signed [SUM_W-1:0]  s_c;
    logic signed [MUL_W-1:0]  s_csq;

    always_comb begin
        s_t   = TRIG_W'(r1_cc >>> 30);
        s_c   = SUM_W'(r2_tc >>> 30) + SUM_W'(r2_ss);
        if (s_c > ONE_Q30)       s_c = ONE_Q30;
        else if (s_c < -ONE_Q30) s_c = -ONE_Q30;
        s_csq = MUL_W'(r3_c) * MUL_W'(r3_c);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
        end else begin
            r1_valid <= s_trig_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
            r5_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_cc   <= MUL_W'(s_c1) * MUL_W'(s_c2);
        r1_ss   <= MUL_W'(s_s1) * MUL_W'(s_s2);
        r1_cd   <= s_cd;
        r1_same <= s_trig_same;
        r2_tc   <= MUL_W'(s_t) * MUL_W'(r1_cd);
        r2_ss   <= TRIG_W'(r1_ss >>> 30);
        r2_same <= r1_same;
        r3_c    <= TRIG_W'(s_c);
        r3_same <= r2_same;
        r4_csq  <= s_csq[RAD_W-1:0];
        r4_cabs <= r3_c[TRIG_W-1] ? ROOT_W'(-r3_c) : ROOT_W'(r3_c);
        r4_neg  <= r3_c[TRIG_W-1];
        r4_same <= r3_same;
        r5_rad  <= (RAD_W'(1) << 60) - r4_csq;
        r5_cabs <= r4_cabs;
        r5_neg  <= r4_neg;
        r5_same <= r4_same;
    end

    // Square root, then the angle of (|cos|, sin) by vectoring.
    logic              s_sq_valid;
    logic [ROOT_W-1:0] s_root;
    logic [ROOT_W+1:0] s_sq_side;

    gcde_isqrt #(.SIDE_W(ROOT_W + 2)) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r5_valid),
        .i_rad   (r5_rad),
        .i_side  ({r5_same, r5_neg, r5_cabs}),
        .o_valid (s_sq_valid),
        .o_root  (s_root),
        .o_side  (s_sq_side)
    );

    logic                    s_vec_valid;
    logic signed [ANG_W-1:0] s_z;
    logic [1:0]              s_vec_side;

    gcde_vec #(.STAGES(CORDIC_STAGES), .SIDE_W(2)) u_vec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_sq_valid),
        .i_x     (s_sq_side[ROOT_W-1:0]),
        .i_y     (s_root),
        .i_side  (s_sq_side[ROOT_W+1:ROOT_W]),
        .o_valid (s_vec_valid),
        .o_z     (s_z),
        .o_side  (s_vec_side)
    );

    // A negative cosine puts theta in the second quadrant.
    logic signed [ANG_W:0] s_th;
    logic [DP_W-1:0]       s_dprod;

    logic              r6_valid, r7_valid;
    logic              r6_same, r7_same;
    logic [TH_W-1:0]   r6_th;
    logic [DIST_W-1:0] r7_dist;

    always_comb begin
        s_th = s_vec_side[0] ? PI_S - (ANG_W + 1)'(s_z) : (ANG_W + 1)'(s_z);
        if (s_th < 0)         s_th = '0;
        else if (s_th > PI_S) s_th = PI_S;
        s_dprod = DP_W'(r6_th) * DP_W'(gcde_pkg::EARTH_RADIUS_M);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_valid <= 1'b0;
            r7_valid <= 1'b0;
        end else begin
            r6_valid <= s_vec_valid;
            r7_valid <= r6_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r6_th   <= TH_W'(s_th);
        r6_same <= s_vec_side[1];
        r7_dist <= s_dprod[DIST_W+29:30];
        r7_same <= r6_same;
    end

    // Rounded-up quotient: (distance + speed - 1) / speed.
    logic              s_div_valid;
    logic [NUM_W-1:0]  s_quo;
    logic [DIST_W:0]   s_div_side;

    gcde_div #(.SIDE_W(DIST_W + 1)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r7_valid),
        .i_num   (NUM_W'(r7_dist) + NUM_W'(r_speed) - NUM_W'(1)),
        .i_den   (r_speed),
        .i_side  ({r7_same, r7_dist}),
        .o_valid (s_div_valid),
        .o_quo   (s_quo),
        .o_side  (s_div_side)
    );

    // Output register.
    logic              r_done;
    logic [DIST_W-1:0] r_dist, r_dur;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_done <= 1'b0;
        else          r_done <= s_div_valid;
    end

    always_ff @(posedge i_clk) begin
        if (s_div_side[DIST_W]) begin
            r_dist <= '0;
            r_dur  <= '0;
        end else begin
            r_dist <= s_div_side[DIST_W-1:0];
            r_dur  <= (r_speed == '0) ? '1 : s_quo[DIST_W-1:0];
        end
    end

    assign o_done       = r_done;
    assign o_distance_m = r_dist;
    assign o_duration_s = r_dur;

endmodule
